/* sv/hs_pkg.sv */
package hs_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = ADDR_W + 2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [CHILD_W-1:0]       child_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		addr_t raddr;
	} mem_req_t;

endpackage

/* sv/hs_if.sv */
interface hs_in_if import hs_pkg::*;;
	logic  valid;
	logic  ready;
	data_t value;
	logic  last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink (input valid, input value, input last_item, output ready);
endinterface

interface hs_out_if import hs_pkg::*;;
	logic  valid;
	logic  ready;
	data_t sorted_value;
	logic  last_out;
	logic  overflow;

	modport source (output valid, output sorted_value, output last_out, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input last_out, input overflow,
		output ready);
endinterface

/* sv/hs_mem.sv */
module hs_mem import hs_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output data_t    rdata
);

	data_t store_q [CAPACITY];
	data_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			store_q[req.waddr] <= req.wdata;
		end
		rdata_q <= store_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/hs_seq.sv */
module hs_seq import hs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hs_in_if.sink       din,
	hs_out_if.source    dout,
	output mem_req_t    req,
	input  data_t       rdata
);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_BUILD_RD,
		ST_BUILD_WT,
		ST_EXT_RD0,
		ST_EXT_RDK,
		ST_EXT_SWAP,
		ST_SIFT_L,
		ST_SIFT_R,
		ST_SIFT_C,
		ST_OUT_RD,
		ST_OUT_WT,
		ST_OUT_HOLD
	} state_t;

	state_t state_q;
	cnt_t   cnt_q;
	logic   drop_q;
	logic   build_q;
	cnt_t   k_q;
	cnt_t   size_q;
	addr_t  node_q;
	data_t  nv_q;
	data_t  bv_q;
	addr_t  big_q;
	data_t  v0_q;
	addr_t  idx_q;
	data_t  out_val_q;
	logic   out_last_q;
	logic   out_ovf_q;
	logic   out_valid_q;

	logic   full;
	cnt_t   cnt_nxt;
	child_t lc;
	child_t rc;
	logic   lc_in;
	logic   rc_in;
	data_t  cmp_b;
	logic   gt;
	addr_t  k_dec;

	assign full    = (cnt_q == cnt_t'(CAPACITY));
	assign cnt_nxt = full ? cnt_q : cnt_q + cnt_t'(1);
	assign lc      = (child_t'(node_q) << 1) + child_t'(1);
	assign rc      = (child_t'(node_q) << 1) + child_t'(2);
	assign lc_in   = lc < child_t'(size_q);
	assign rc_in   = rc < child_t'(size_q);
	assign k_dec   = addr_t'(k_q - cnt_t'(1));

	// The single comparator: a freshly read child against the best value so far.
	assign cmp_b = (state_q == ST_SIFT_R) ? nv_q : bv_q;
	assign gt    = rdata > cmp_b;

	assign din.ready         = (state_q == ST_LOAD);
	assign dout.valid        = out_valid_q;
	assign dout.sorted_value = out_val_q;
	assign dout.last_out     = out_last_q;
	assign dout.overflow     = out_ovf_q;

	always_comb begin
		req       = '0;
		req.wdata = nv_q;
		unique case (state_q)
			ST_LOAD: begin
				req.we    = din.valid && !full;
				req.waddr = cnt_q[ADDR_W-1:0];
				req.wdata = din.value;
			end
			ST_BUILD_RD: req.raddr = k_dec;
			ST_EXT_RD0:  req.raddr = '0;
			ST_EXT_RDK:  req.raddr = k_q[ADDR_W-1:0];
			ST_EXT_SWAP: begin
				req.we    = 1'b1;
				req.waddr = k_q[ADDR_W-1:0];
				req.wdata = v0_q;
			end
			ST_SIFT_L: begin
				req.raddr = lc[ADDR_W-1:0];
				req.we    = !lc_in;
				req.waddr = node_q;
				req.wdata = nv_q;
			end
			ST_SIFT_R: req.raddr = rc[ADDR_W-1:0];
			ST_SIFT_C: begin
				// The hole moves down: the winning child fills it, or the
				// sifted value settles here.
				req.we    = 1'b1;
				req.waddr = node_q;
				if (rc_in && gt) begin
					req.wdata = rdata;
				end else if (big_q != node_q) begin
					req.wdata = bv_q;
				end else begin
					req.wdata = nv_q;
				end
			end
			ST_OUT_RD:   req.raddr = idx_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			build_q     <= 1'b0;
			k_q         <= '0;
			size_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (din.valid) begin
						cnt_q <= cnt_nxt;
						if (full) begin
							drop_q <= 1'b1;
						end
						if (din.last_item) begin
							idx_q <= '0;
							if (cnt_nxt < cnt_t'(2)) begin
								state_q <= ST_OUT_RD;
							end else begin
								size_q  <= cnt_nxt;
								k_q     <= cnt_nxt >> 1;
								build_q <= 1'b1;
								state_q <= ST_BUILD_RD;
							end
						end
					end
				end
				ST_BUILD_RD: state_q <= ST_BUILD_WT;
				ST_BUILD_WT: begin
					nv_q    <= rdata;
					node_q  <= k_dec;
					state_q <= ST_SIFT_L;
				end
				ST_EXT_RD0:  state_q <= ST_EXT_RDK;
				ST_EXT_RDK: begin
					v0_q    <= rdata;
					state_q <= ST_EXT_SWAP;
				end
				ST_EXT_SWAP: begin
					nv_q    <= rdata;
					node_q  <= '0;
					size_q  <= k_q;
					state_q <= ST_SIFT_L;
				end
				ST_SIFT_L: begin
					if (lc_in) begin
						state_q <= ST_SIFT_R;
					end else if (k_q == cnt_t'(1)) begin
						// This pass is over; either extraction starts or the
						// sorted store is read out.
						if (build_q) begin
							build_q <= 1'b0;
							k_q     <= cnt_q - cnt_t'(1);
							state_q <= ST_EXT_RD0;
						end else begin
							state_q <= ST_OUT_RD;
						end
					end else begin
						k_q     <= k_q - cnt_t'(1);
						state_q <= build_q ? ST_BUILD_RD : ST_EXT_RD0;
					end
				end
				ST_SIFT_R: begin
					bv_q    <= gt ? rdata : nv_q;
					big_q   <= gt ? lc[ADDR_W-1:0] : node_q;
					state_q <= ST_SIFT_C;
				end
				ST_SIFT_C: begin
					if (rc_in && gt) begin
						node_q  <= rc[ADDR_W-1:0];
						state_q <= ST_SIFT_L;
					end else if (big_q != node_q) begin
						node_q  <= big_q;
						state_q <= ST_SIFT_L;
					end else if (k_q == cnt_t'(1)) begin
						if (build_q) begin
							build_q <= 1'b0;
							k_q     <= cnt_q - cnt_t'(1);
							state_q <= ST_EXT_RD0;
						end else begin
							state_q <= ST_OUT_RD;
						end
					end else begin
						k_q     <= k_q - cnt_t'(1);
						state_q <= build_q ? ST_BUILD_RD : ST_EXT_RD0;
					end
				end
				ST_OUT_RD:   state_q <= ST_OUT_WT;
				ST_OUT_WT: begin
					out_val_q   <= rdata;
					out_last_q  <= (cnt_t'(idx_q) == cnt_q - cnt_t'(1));
					out_ovf_q   <= drop_q;
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT_HOLD;
				end
				ST_OUT_HOLD: begin
					if (dout.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + addr_t'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_drop_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> full)
		else $error("overflow flag set while the store still has room");

	a_sift_node_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIFT_L || state_q == ST_SIFT_R || state_q == ST_SIFT_C)
		|-> cnt_t'(node_q) < size_q)
		else $error("sift node outside the heap");

	a_heap_within_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> (size_q <= cnt_q && cnt_q != '0))
		else $error("heap size exceeds the loaded count");

	a_write_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req.we && state_q != ST_LOAD) |-> cnt_t'(req.waddr) < cnt_q)
		else $error("sort writes beyond the loaded elements");

	a_beat_follows_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT_WT)
		else $error("result beat raised without a store read");

endmodule

/* sv/heap_sorter_top.sv */
// Heap sorter: beats carrying signed 32-bit values are loaded into a 64-entry store, one
// per cycle, until a beat with last_item set closes the set; beats past the store's
// capacity are dropped and flag overflow on every result of that set. The set is then
// heapsorted in place by one comparator and a single-port-read memory, each sift-down
// level passing through the states SIFT_L, SIFT_R and SIFT_C. The elements then leave
// in ascending order, each beat read from the store and held until the sink takes it,
// the largest one carrying last_out.
// The input is not ready from the closing beat until the last result has been taken.
module heap_sorter_top import hs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	hs_in_if.sink    din,
	hs_out_if.source dout
);

	mem_req_t req;
	data_t    rdata;

	hs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.req    (req),
		.rdata  (rdata)
	);

	hs_mem u_mem (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule
